FILE: design/assert_macros.svh
// Assertion helpers used by quaternion_slerp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/qslerp_pkg.sv
package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int NSTEPS       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int WQ           = 30;
    localparam int C_LSH        = WQ - 2 * FRAC_BITS;
    localparam int F_LSH        = WQ - FRAC_BITS;

    localparam logic [14:0] ONE_IO    = 15'(1 << FRAC_BITS);
    localparam logic [30:0] ONE_W     = 31'(1) << WQ;
    localparam logic [30:0] COS_LIMIT = ONE_W - 31'((2 ** WQ) / 10000);

    localparam int ISQRT_STEPS = 32;
    localparam int ISQRT_PER   = 2;
    localparam int ISQRT_LAT   = ISQRT_STEPS / ISQRT_PER;
    localparam int DIV_STEPS   = FRAC_BITS + 2;
    localparam int DIV_LAT     = DIV_STEPS;
    localparam int NORM_LAT    = 6;

    // input, product, dot, square | isqrt | vectoring | angle product | rotation |
    // weights, blend products, sum, magnitude, max | normalize | squares, sum |
    // isqrt | divide | output
    localparam int VLEN = 4 + ISQRT_LAT + NSTEPS + 1 + NSTEPS + 5 + NORM_LAT + 2
                          + ISQRT_LAT + DIV_LAT + 1;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef struct packed {
        logic [63:0] x;
        logic [35:0] r;
        logic [31:0] q;
    } t_sqrt;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } t_cordic;

    typedef struct packed {
        logic [47:0]          n;
        logic [31:0]          d;
        logic [DIV_STEPS-1:0] q;
    } t_div;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [30:0]      f;
        logic [30:0]      g;
        logic [30:0]      c;
        logic             neg;
        logic             lin;
    } t_side;

    typedef struct packed {
        logic [3:0][30:0] nm;
        logic [3:0]       sgn;
        logic             zero;
    } t_nside;

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       o;
        logic [35:0] rr;
        logic [35:0] tt;
        rr  = {s.r[33:0], s.x[63:62]};
        tt  = {2'b00, s.q, 2'b01};
        o.x = {s.x[61:0], 2'b00};
        if (rr >= tt) begin
            o.r = rr - tt;
            o.q = {s.q[30:0], 1'b1};
        end else begin
            o.r = rr;
            o.q = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

FILE: design/qslerp_if.sv
interface qslerp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic        [14:0] blend;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                  output ready);
endinterface

interface qslerp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic signed [15:0] r_w;

    modport source (output valid, r_x, r_y, r_z, r_w, input ready);
    modport sink (input valid, r_x, r_y, r_z, r_w, output ready);
endinterface

FILE: design/qslerp_isqrt.sv
module qslerp_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_q
);

    qslerp_pkg::t_sqrt r_st [qslerp_pkg::ISQRT_LAT];
    qslerp_pkg::t_sqrt n_st [qslerp_pkg::ISQRT_LAT];

    genvar j;
    generate
        for (j = 0; j < qslerp_pkg::ISQRT_LAT; j++) begin : g_stage
            always_comb begin
                qslerp_pkg::t_sqrt cur;
                if (j == 0) begin
                    cur.x = i_x;
                    cur.r = '0;
                    cur.q = '0;
                end else begin
                    cur = r_st[(j == 0) ? 0 : j - 1];
                end
                for (int k = 0; k < qslerp_pkg::ISQRT_PER; k++) begin
                    cur = qslerp_pkg::sqrt_step(cur);
                end
                n_st[j] = cur;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[j] <= n_st[j];
                end
            end
        end
    endgenerate

    assign o_q = r_st[qslerp_pkg::ISQRT_LAT-1].q;

endmodule

FILE: design/qslerp_cordic_vec.sv
module qslerp_cordic_vec (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic signed [33:0] o_z
);

    qslerp_pkg::t_cordic r_st [qslerp_pkg::NSTEPS];
    qslerp_pkg::t_cordic n_st [qslerp_pkg::NSTEPS];

    genvar i;
    generate
        for (i = 0; i < qslerp_pkg::NSTEPS; i++) begin : g_stage
            always_comb begin
                logic signed [33:0] x;
                logic signed [33:0] y;
                logic signed [33:0] z;
                logic signed [33:0] dx;
                logic signed [33:0] dy;
                logic signed [33:0] at;
                if (i == 0) begin
                    x = i_x;
                    y = i_y;
                    z = '0;
                end else begin
                    x = $signed(r_st[(i == 0) ? 0 : i - 1].x);
                    y = $signed(r_st[(i == 0) ? 0 : i - 1].y);
                    z = $signed(r_st[(i == 0) ? 0 : i - 1].z);
                end
                dx = y >>> i;
                dy = x >>> i;
                at = $signed({2'b00, qslerp_pkg::ATAN_TAB[i]});
                if (!y[33]) begin
                    n_st[i].x = x + dx;
                    n_st[i].y = y - dy;
                    n_st[i].z = z + at;
                end else begin
                    n_st[i].x = x - dx;
                    n_st[i].y = y + dy;
                    n_st[i].z = z - at;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[i] <= n_st[i];
                end
            end
        end
    endgenerate

    assign o_z = $signed(r_st[qslerp_pkg::NSTEPS-1].z);

endmodule

FILE: design/qslerp_cordic_rot.sv
module qslerp_cordic_rot (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_z,
    output logic signed [33:0] o_y
);

    qslerp_pkg::t_cordic r_st [qslerp_pkg::NSTEPS];
    qslerp_pkg::t_cordic n_st [qslerp_pkg::NSTEPS];

    genvar i;
    generate
        for (i = 0; i < qslerp_pkg::NSTEPS; i++) begin : g_stage
            always_comb begin
                logic signed [33:0] x;
                logic signed [33:0] y;
                logic signed [33:0] z;
                logic signed [33:0] dx;
                logic signed [33:0] dy;
                logic signed [33:0] at;
                if (i == 0) begin
                    x = $signed({3'b000, qslerp_pkg::ONE_W});
                    y = '0;
                    z = i_z;
                end else begin
                    x = $signed(r_st[(i == 0) ? 0 : i - 1].x);
                    y = $signed(r_st[(i == 0) ? 0 : i - 1].y);
                    z = $signed(r_st[(i == 0) ? 0 : i - 1].z);
                end
                dx = y >>> i;
                dy = x >>> i;
                at = $signed({2'b00, qslerp_pkg::ATAN_TAB[i]});
                if (!z[33]) begin
                    n_st[i].x = x - dx;
                    n_st[i].y = y + dy;
                    n_st[i].z = z - at;
                end else begin
                    n_st[i].x = x + dx;
                    n_st[i].y = y - dy;
                    n_st[i].z = z + at;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[i] <= n_st[i];
                end
            end
        end
    endgenerate

    assign o_y = $signed(r_st[qslerp_pkg::NSTEPS-1].y);

endmodule

FILE: design/qslerp_div.sv
module qslerp_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [47:0]                      i_num,
    input  logic [31:0]                      i_den,
    output logic [qslerp_pkg::DIV_STEPS-1:0] o_q
);

    qslerp_pkg::t_div r_st [qslerp_pkg::DIV_LAT];
    qslerp_pkg::t_div n_st [qslerp_pkg::DIV_LAT];

    genvar k;
    generate
        for (k = 0; k < qslerp_pkg::DIV_LAT; k++) begin : g_stage
            localparam int SH = qslerp_pkg::DIV_STEPS - 1 - k;
            always_comb begin
                qslerp_pkg::t_div cur;
                logic [47:0]      dd;
                if (k == 0) begin
                    cur.n = i_num;
                    cur.d = i_den;
                    cur.q = '0;
                end else begin
                    cur = r_st[(k == 0) ? 0 : k - 1];
                end
                dd = 48'(cur.d) << SH;
                n_st[k].d = cur.d;
                if (cur.n >= dd) begin
                    n_st[k].n = cur.n - dd;
                    n_st[k].q = {cur.q[qslerp_pkg::DIV_STEPS-2:0], 1'b1};
                end else begin
                    n_st[k].n = cur.n;
                    n_st[k].q = {cur.q[qslerp_pkg::DIV_STEPS-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_q = r_st[qslerp_pkg::DIV_LAT-1].q;

endmodule

FILE: design/quaternion_slerp.sv
// Quaternion slerp, one item per cycle.
// i_in carries unit quaternions a and b (Q2.14) and the blend factor; a
// transfer happens when valid and ready are both high. o_out carries the
// normalized interpolated quaternion (Q2.14), one result per input.
// From input transfer to o_out.valid the data passes four front stages,
// a 16-stage integer square root, 16-stage vectoring and rotation CORDICs,
// a six-stage normalizing shifter, a second 16-stage square root and
// 16-stage restoring dividers, one step per stage (two in the square roots).
// Throughput is one item per cycle while the receiver takes results.
// The pipeline moves as a whole: when o_out.valid is high and o_out.ready is
// low, every stage holds and i_in.ready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and holds
// i_in.ready low; data registers are not reset.
`include "assert_macros.svh"

module quaternion_slerp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qslerp_in_if.sink      i_in,
    qslerp_out_if.source   o_out
);

    localparam int VL  = qslerp_pkg::VLEN;
    localparam int IL  = qslerp_pkg::ISQRT_LAT;
    localparam int NS  = qslerp_pkg::NSTEPS;
    localparam int NL  = qslerp_pkg::NORM_LAT;
    localparam int DL  = qslerp_pkg::DIV_LAT;
    localparam int FB  = qslerp_pkg::FRAC_BITS;

    logic          en;
    logic [VL-1:0] r_vld;

    assign en         = !r_vld[VL-1] || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VL-2:0], i_in.valid};
        end
    end

    // front: input, products, dot, cosine square
    qslerp_pkg::t_side  n_s1;
    qslerp_pkg::t_side  r_s1;
    qslerp_pkg::t_side  r_s2;
    qslerp_pkg::t_side  n_s3;
    qslerp_pkg::t_side  r_s3;
    qslerp_pkg::t_side  r_s4;
    logic signed [31:0] r_p [4];
    logic        [61:0] r_c2;
    logic        [14:0] fb;

    always_comb begin
        fb       = (i_in.blend > qslerp_pkg::ONE_IO) ? qslerp_pkg::ONE_IO : i_in.blend;
        n_s1.a   = {i_in.a_w, i_in.a_z, i_in.a_y, i_in.a_x};
        n_s1.b   = {i_in.b_w, i_in.b_z, i_in.b_y, i_in.b_x};
        n_s1.f   = 31'(fb) << qslerp_pkg::F_LSH;
        n_s1.g   = qslerp_pkg::ONE_W - (31'(fb) << qslerp_pkg::F_LSH);
        n_s1.c   = '0;
        n_s1.neg = 1'b0;
        n_s1.lin = 1'b0;
    end

    always_comb begin
        logic signed [33:0] dot;
        logic        [33:0] dm;
        logic        [35:0] cf;
        dot = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]) + 34'(r_p[3]);
        dm  = dot[33] ? 34'(-dot) : 34'(dot);
        cf  = 36'(dm) << qslerp_pkg::C_LSH;
        n_s3     = r_s2;
        n_s3.neg = dot[33];
        n_s3.c   = (cf > 36'(qslerp_pkg::ONE_W)) ? qslerp_pkg::ONE_W : cf[30:0];
        n_s3.lin = (n_s3.c >= qslerp_pkg::COS_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= $signed(r_s1.a[k]) * $signed(r_s1.b[k]);
            end
            r_s2 <= r_s1;
            r_s3 <= n_s3;
            r_c2 <= r_s3.c * r_s3.c;
            r_s4 <= r_s3;
        end
    end

    // sine of the angle, then the angle
    logic [60:0] sq_in;
    logic [31:0] sin_q;
    logic signed [33:0] ang;
    qslerp_pkg::t_side r_d1 [IL + NS];

    assign sq_in = {1'b1, 60'd0} - {1'b0, r_c2[59:0]} - {r_c2[60], 60'd0};

    qslerp_isqrt u_isqrt_sin (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (64'(sq_in)),
        .o_q   (sin_q)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= r_s4;
            for (int k = 1; k < IL + NS; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    qslerp_cordic_vec u_vec (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed({3'b000, r_d1[IL-1].c})),
        .i_y   ($signed({2'b00, sin_q})),
        .o_z   (ang)
    );

    // scaled angles and weights
    logic        [30:0] uw;
    logic        [61:0] r_pg;
    logic        [61:0] r_pf;
    qslerp_pkg::t_side  r_sm;
    qslerp_pkg::t_side  r_d2 [NS];
    logic        [62:0] zg;
    logic        [62:0] zf;
    logic signed [33:0] y0;
    logic signed [33:0] y1;

    assign uw = ang[33] ? 31'd0 : ang[30:0];
    assign zg = {1'b0, r_pg} + (63'(1) << (qslerp_pkg::WQ - 1));
    assign zf = {1'b0, r_pf} + (63'(1) << (qslerp_pkg::WQ - 1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pg    <= r_d1[IL+NS-1].g * uw;
            r_pf    <= r_d1[IL+NS-1].f * uw;
            r_sm    <= r_d1[IL+NS-1];
            r_d2[0] <= r_sm;
            for (int k = 1; k < NS; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    qslerp_cordic_rot u_rot0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   ($signed({2'b00, zg[61:30]})),
        .o_y   (y0)
    );

    qslerp_cordic_rot u_rot1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   ($signed({2'b00, zf[61:30]})),
        .o_y   (y1)
    );

    // weights, blend, magnitudes
    logic signed [33:0] r_w0;
    logic signed [33:0] r_w1;
    qslerp_pkg::t_side  r_sw;
    logic signed [49:0] r_m0 [4];
    logic signed [49:0] r_m1 [4];
    logic signed [50:0] r_acc [4];
    logic        [50:0] r_mag [4];
    logic        [3:0]  r_sgn;
    logic signed [33:0] n_w0;
    logic signed [33:0] n_w1;

    always_comb begin
        qslerp_pkg::t_side sr;
        sr   = r_d2[NS-1];
        n_w0 = sr.lin ? $signed({3'b000, sr.g}) : y0;
        n_w1 = sr.lin ? $signed({3'b000, sr.f}) : y1;
        if (sr.neg) begin
            n_w1 = -n_w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
            r_sw <= r_d2[NS-1];
            for (int k = 0; k < 4; k++) begin
                r_m0[k]  <= r_w0 * $signed(r_sw.a[k]);
                r_m1[k]  <= r_w1 * $signed(r_sw.b[k]);
                r_acc[k] <= 51'(r_m0[k]) + 51'(r_m1[k]);
                r_mag[k] <= r_acc[k][50] ? 51'(-r_acc[k]) : 51'(r_acc[k]);
                r_sgn[k] <= r_acc[k][50];
            end
        end
    end

    // normalizing shifter: word 0 is the max, words 1..4 the components
    logic [63:0] r_nw [NL+1][5];
    logic [3:0]  r_nsg [NL+1];
    logic [50:0] mx01;
    logic [50:0] mx23;
    logic [50:0] mx;

    assign mx01 = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign mx23 = (r_mag[2] > r_mag[3]) ? r_mag[2] : r_mag[3];
    assign mx   = (mx01 > mx23) ? mx01 : mx23;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nw[0][0] <= 64'(mx);
            for (int k = 0; k < 4; k++) begin
                r_nw[0][k+1] <= 64'(r_mag[k]);
            end
            r_nsg[0] <= r_sgn;
        end
    end

    genvar j;
    generate
        for (j = 1; j <= NL; j++) begin : g_norm
            localparam int SH = 64 >> j;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_nsg[j] <= r_nsg[j-1];
                    for (int k = 0; k < 5; k++) begin
                        if (r_nw[j-1][0][63 -: SH] == '0) begin
                            r_nw[j][k] <= r_nw[j-1][k] << SH;
                        end else begin
                            r_nw[j][k] <= r_nw[j-1][k];
                        end
                    end
                end
            end
        end
    endgenerate

    // sum of squares, norm, division
    qslerp_pkg::t_nside n_nq;
    qslerp_pkg::t_nside r_nq;
    qslerp_pkg::t_nside r_nu;
    qslerp_pkg::t_nside r_d3 [IL];
    qslerp_pkg::t_nside r_d4 [DL];
    logic [61:0] r_sq [4];
    logic [63:0] r_sum;
    logic [31:0] nrm;
    logic [DL-1:0] quo [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_nq.nm[k] = r_nw[NL][k+1][63:33];
        end
        n_nq.sgn  = r_nsg[NL];
        n_nq.zero = (r_nw[NL][0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nq <= n_nq;
            for (int k = 0; k < 4; k++) begin
                r_sq[k] <= n_nq.nm[k] * n_nq.nm[k];
            end
            r_nu  <= r_nq;
            r_sum <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]) + 64'(r_sq[3]);
            r_d3[0] <= r_nu;
            for (int k = 1; k < IL; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
            r_d4[0] <= r_d3[IL-1];
            for (int k = 1; k < DL; k++) begin
                r_d4[k] <= r_d4[k-1];
            end
        end
    end

    qslerp_isqrt u_isqrt_norm (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_sum),
        .o_q   (nrm)
    );

    genvar d;
    generate
        for (d = 0; d < 4; d++) begin : g_div
            qslerp_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num ((48'(r_d3[IL-1].nm[d]) << FB) + 48'(nrm[31:1])),
                .i_den (nrm),
                .o_q   (quo[d])
            );
        end
    endgenerate

    // output register with saturation
    logic signed [15:0] r_o [4];
    logic signed [15:0] n_o [4];

    always_comb begin
        logic [16:0] qq;
        for (int k = 0; k < 4; k++) begin
            qq = 17'(quo[k]);
            if (r_d4[DL-1].zero) begin
                n_o[k] = '0;
            end else if (r_d4[DL-1].sgn[k]) begin
                n_o[k] = (qq > 17'd32768) ? -16'sd32768 : $signed(16'(17'd0 - qq));
            end else begin
                n_o[k] = (qq > 17'd32767) ? 16'sd32767 : $signed(qq[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_o[k] <= n_o[k];
            end
        end
    end

    assign o_out.valid = r_vld[VL-1];
    assign o_out.r_x   = r_o[0];
    assign o_out.r_y   = r_o[1];
    assign o_out.r_z   = r_o[2];
    assign o_out.r_w   = r_o[3];

    logic out_in_rng;

    assign out_in_rng = (o_out.r_x >= -16'sd16384) && (o_out.r_x <= 16'sd16384)
                     && (o_out.r_y >= -16'sd16384) && (o_out.r_y <= 16'sd16384)
                     && (o_out.r_z >= -16'sd16384) && (o_out.r_z <= 16'sd16384)
                     && (o_out.r_w >= -16'sd16384) && (o_out.r_w <= 16'sd16384);

    `QS_ASSERT_NEXT(a_in_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "lost transfer")
    `QS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !en, $stable(r_vld), "valid chain moved")
    `QS_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, o_out.valid, out_in_rng, "result out of range")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        shortint    a[4];
        shortint    b[4];
        bit [14:0]  blend;
    } t_slerp_req;

    typedef struct {
        shortint r[4];
    } t_quat;

    class t_slerp_scoreboard;
        t_quat  pending_q[$];
        int     fail_cnt;

        function new();
            fail_cnt = 0;
        endfunction

        function void note_input(t_quat exp_q);
            pending_q.push_back(exp_q);
        endfunction

        function void check_result(t_quat got);
            t_quat  exp_q;
            string  nm[4];
            nm = '{"r_x", "r_y", "r_z", "r_w"};
            if (pending_q.size() == 0) begin
                $error("result with no pending expectation");
                fail_cnt++;
                return;
            end
            exp_q = pending_q.pop_front();
            for (int k = 0; k < 4; k++) begin
                if (exp_q.r[k] != got.r[k]) begin
                    $error("%s mismatch: expected %0d actual %0d", nm[k], exp_q.r[k], got.r[k]);
                    fail_cnt++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    qslerp_in_if  in_if();
    qslerp_out_if out_if();

    quaternion_slerp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_slerp_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req_cnt;
    int hold_seen_cnt;
    int hold_left;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt >>= 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint cordic_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < qslerp_pkg::NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(qslerp_pkg::ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(qslerp_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint cordic_sin(longint z);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = longint'(1) << qslerp_pkg::WQ;
        y = 0;
        for (int i = 0; i < qslerp_pkg::NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(qslerp_pkg::ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(qslerp_pkg::ATAN_TAB[i]);
            end
        end
        return y;
    endfunction

    function automatic t_quat slerp_expect(t_slerp_req req);
        t_quat           res;
        longint          dot;
        longint          w0;
        longint          w1;
        longint          acc;
        longint unsigned dm, c, fb, f, g, m, sum, n, s, uw, q, half;
        longint unsigned mag[4];
        bit              neg;
        bit              sgn[4];
        int              rs, ls;
        dot = 0;
        m   = 0;
        sum = 0;
        for (int k = 0; k < 4; k++)
            dot += longint'(req.a[k]) * longint'(req.b[k]);
        neg = dot < 0;
        dm  = neg ? longint'(-dot) : dot;
        if (qslerp_pkg::C_LSH >= 0)
            c = dm << qslerp_pkg::C_LSH;
        else
            c = (dm + (64'd1 << (-qslerp_pkg::C_LSH - 1))) >> (-qslerp_pkg::C_LSH);
        if (c > 64'(qslerp_pkg::ONE_W))
            c = 64'(qslerp_pkg::ONE_W);
        fb = 64'(req.blend);
        if (fb > 64'(qslerp_pkg::ONE_IO))
            fb = 64'(qslerp_pkg::ONE_IO);
        f = fb << qslerp_pkg::F_LSH;
        g = 64'(qslerp_pkg::ONE_W) - f;
        if (c < 64'(qslerp_pkg::COS_LIMIT)) begin
            s    = int_sqrt((64'd1 << (2 * qslerp_pkg::WQ)) - c * c);
            acc  = cordic_angle(longint'(c), longint'(s));
            uw   = acc < 0 ? 0 : acc;
            half = 64'd1 << (qslerp_pkg::WQ - 1);
            w0   = cordic_sin(longint'((g * uw + half) >> qslerp_pkg::WQ));
            w1   = cordic_sin(longint'((f * uw + half) >> qslerp_pkg::WQ));
        end else begin
            w0 = g;
            w1 = f;
        end
        if (neg)
            w1 = -w1;
        for (int k = 0; k < 4; k++) begin
            acc    = w0 * req.a[k] + w1 * req.b[k];
            sgn[k] = acc < 0;
            mag[k] = sgn[k] ? longint'(-acc) : acc;
            if (mag[k] > m)
                m = mag[k];
        end
        if (m == 0) begin
            for (int k = 0; k < 4; k++)
                res.r[k] = 0;
            return res;
        end
        rs = 0;
        ls = 0;
        while ((m >> rs) >= (64'd1 << 31))
            rs++;
        while ((m << ls) < (64'd1 << 30))
            ls++;
        for (int k = 0; k < 4; k++) begin
            mag[k] = (mag[k] >> rs) << ls;
            sum += mag[k] * mag[k];
        end
        n = int_sqrt(sum);
        for (int k = 0; k < 4; k++) begin
            q = (mag[k] * 64'(qslerp_pkg::ONE_IO) + n / 2) / n;
            if (sgn[k])
                res.r[k] = q > 32768 ? -32768 : -shortint'(q);
            else
                res.r[k] = q > 32767 ? 32767 : shortint'(q);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_slerp_req req;
        t_quat      got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                req.a = '{in_if.a_x, in_if.a_y, in_if.a_z, in_if.a_w};
                req.b = '{in_if.b_x, in_if.b_y, in_if.b_z, in_if.b_w};
                req.blend = in_if.blend;
                sb.note_input(slerp_expect(req));
            end
            if (out_if.valid && out_if.ready) begin
                got.r = '{out_if.r_x, out_if.r_y, out_if.r_z, out_if.r_w};
                sb.check_result(got);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_req(t_slerp_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.a_x   <= req.a[0];
        in_if.a_y   <= req.a[1];
        in_if.a_z   <= req.a[2];
        in_if.a_w   <= req.a[3];
        in_if.b_x   <= req.b[0];
        in_if.b_y   <= req.b[1];
        in_if.b_z   <= req.b[2];
        in_if.b_w   <= req.b[3];
        in_if.blend <= req.blend;
        in_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_quats(shortint a[4], shortint b[4], bit [14:0] blend);
        t_slerp_req req;
        req.a = a;
        req.b = b;
        req.blend = blend;
        send_req(req);
    endtask

    function automatic void unit_quat(output shortint q[4], input real base[4], input real jit);
        real v[4];
        real nrm;
        nrm = 0.0;
        for (int k = 0; k < 4; k++) begin
            v[k] = base[k] + jit * ($urandom_range(65535) / 32768.0 - 1.0);
            nrm += v[k] * v[k];
        end
        if (nrm < 1e-9) begin
            v = '{0.0, 0.0, 0.0, 1.0};
            nrm = 1.0;
        end
        nrm = $sqrt(nrm);
        for (int k = 0; k < 4; k++)
            q[k] = shortint'($rtoi(v[k] / nrm * 16384.0 + (v[k] >= 0 ? 0.5 : -0.5)));
    endfunction

    task automatic send_random();
        t_slerp_req req;
        real        ra[4];
        real        zero4[4];
        int         kind;
        zero4 = '{0.0, 0.0, 0.0, 0.0};
        kind = $urandom_range(99);
        if (kind < 10) begin
            for (int k = 0; k < 4; k++) begin
                req.a[k] = shortint'($urandom);
                req.b[k] = shortint'($urandom);
            end
            req.blend = 15'($urandom);
        end else begin
            unit_quat(req.a, zero4, 1.0);
            for (int k = 0; k < 4; k++)
                ra[k] = req.a[k] / 16384.0;
            if (kind < 40)
                unit_quat(req.b, ra, 0.01 * $urandom_range(0, 3));
            else
                unit_quat(req.b, zero4, 1.0);
            if ($urandom_range(1))
                for (int k = 0; k < 4; k++)
                    req.b[k] = -req.b[k];
            req.blend = ($urandom_range(19) == 0) ? 15'($urandom)
                                                  : 15'($urandom_range(0, 16384));
        end
        send_req(req);
    endtask

    initial begin
        #10_000_000;
        $display("FAIL quaternion_slerp");
        $finish;
    end

    initial begin
        int wait_cnt;
        in_if.valid  = 1'b0;
        in_if.a_x    = '0;
        in_if.a_y    = '0;
        in_if.a_z    = '0;
        in_if.a_w    = '0;
        in_if.b_x    = '0;
        in_if.b_y    = '0;
        in_if.b_z    = '0;
        in_if.b_w    = '0;
        in_if.blend  = '0;
        out_if.ready = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_cnt   = 0;
        hold_seen_cnt  = 0;
        hold_left      = 0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero sum, linear branch, negative dot, blend clamp
        send_quats('{0, 0, 0, 0}, '{0, 0, 0, 0}, 15'd8192);
        send_quats('{0, 0, 0, 16384}, '{0, 0, 0, 16384}, 15'd0);
        send_quats('{0, 0, 0, 16384}, '{0, 0, 0, 16384}, 15'd16384);
        send_quats('{0, 0, 0, 16384}, '{0, 0, 0, -16384}, 15'd8192);
        send_quats('{0, 0, 0, 16384}, '{16384, 0, 0, 0}, 15'd0);
        send_quats('{0, 0, 0, 16384}, '{16384, 0, 0, 0}, 15'd8192);
        send_quats('{0, 0, 0, 16384}, '{16384, 0, 0, 0}, 15'd16384);
        send_quats('{0, 0, 0, 16384}, '{16384, 0, 0, 0}, 15'd32767);
        send_quats('{0, 0, 0, 16384}, '{-16384, 0, 0, 0}, 15'd20000);
        send_quats('{0, 16384, 0, 0}, '{0, 0, -16384, 0}, 15'd4096);
        send_quats('{8192, 8192, 8192, 8192}, '{-8192, -8192, -8192, -8192}, 15'd8192);
        send_quats('{11585, 0, 0, 11585}, '{0, 0, 0, -16384}, 15'd12288);
        send_quats('{32767, 32767, 32767, 32767}, '{32767, 32767, 32767, 32767}, 15'd8192);
        send_quats('{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767, 32767},
                   15'd8192);
        send_quats('{-32768, 32767, -32768, 32767}, '{-32768, 32767, 0, 0}, 15'd1);
        send_quats('{16384, 0, 0, 0}, '{16384, 0, 0, 0}, 15'd16383);
        send_quats('{16384, 0, 0, 0}, '{16383, 181, 0, 0}, 15'd8192);
        send_quats('{0, 0, 16384, 0}, '{0, 0, 0, 0}, 15'd8192);
        send_quats('{0, 0, 0, 0}, '{0, 16384, 0, 0}, 15'd32767);
        send_quats('{16384, 16384, 16384, 16384}, '{16384, -16384, 16384, -16384},
                   15'd16385);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 69 : 33) : 0;
            recv_stall_pct = (ph == 2) ? 69 : ((ph == 3) ? 33 : 0);
            if (ph == 0)
                hold_req_cnt++;
            for (int i = 0; i < 150; i++)
                send_random();
        end
        in_if.valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending_q.size() != 0 && wait_cnt < 200_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (sb.pending_q.size() != 0) begin
            $display("FAIL quaternion_slerp");
            $finish;
        end else begin
            repeat (120) @(posedge i_clk);
            if (sb.fail_cnt == 0)
                $display("PASS quaternion_slerp");
            else
                $display("FAIL quaternion_slerp");
            $finish;
        end
    end
endmodule

FILE: quaternion_slerp.f
+incdir+design
design/qslerp_pkg.sv
design/qslerp_if.sv
design/qslerp_isqrt.sv
design/qslerp_cordic_vec.sv
design/qslerp_cordic_rot.sv
design/qslerp_div.sv
design/quaternion_slerp.sv
tb/sv/tb_top.sv
